// ===== sv/tsp_pkg.sv =====
// Shared types and constants for the tone sweep period generator.
package tsp_pkg;

	localparam int FREQ_W     = 14;   // clamped step frequency width
	localparam int ACC_W      = 18;   // signed running frequency width
	localparam int REM_W      = 20;   // reciprocal remainder width
	localparam int TRIAL_W    = 25;   // widest shifted divisor
	localparam int QBITS      = 12;   // reciprocal quotient bits
	localparam int RCP_SH     = 22;   // front reciprocal shift: 16 dividend bits + 6
	localparam int RCP_W      = 23;   // front reciprocal width
	localparam int STEPS_MAX  = 64;
	localparam int QDEPTH     = 2;

	localparam logic [FREQ_W-1:0] FREQ_MIN   = 14'd260;
	localparam logic [FREQ_W-1:0] FREQ_MAX   = 14'd12600;
	localparam logic [REM_W-1:0]  PERIOD_NUM = 20'd1000000;
	localparam logic [14:0]       TOP_MIN    = 15'd600;
	localparam logic [10:0]       MS_MAX     = 11'd2047;

	typedef struct packed {
		logic [14:0] start_freq;
		logic [14:0] end_freq;
		logic [15:0] total_ms;
	} in_item_t;

	typedef struct packed {
		logic [14:0] timer_top;
		logic [10:0] step_ms;
		logic [5:0]  step_index;
		logic        last_step;
	} out_item_t;

	typedef struct packed {
		logic [14:0]        start_freq;
		logic signed [15:0] inc;
		logic [10:0]        step_ms;
	} job_t;

	typedef struct packed {
		logic [10:0] step_ms;
		logic [5:0]  step_index;
		logic        last_step;
	} side_t;

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_DIV,
		FR_PUSH
	} front_state_t;

endpackage

// ===== sv/tone_sweep_period_generator.sv =====
// Tone sweep period generator: splits a sweep request into STEPS tone steps.
//
// Input channel (in_valid/in_ready/in_item): one transfer is one sweep request
// of start frequency, end frequency and total duration in ms.
// Output channel (out_valid/out_ready/out_item): STEPS transfers per request,
// each with the timer top count, step length, step index and last-step flag.
// The front end works out the frequency increment and step length by
// reciprocal multiplication, one request at a time, and hands a job to a
// two-entry queue. The back end issues one step per cycle while the output
// is not stalled, into a 12-stage reciprocal pipeline. The first step of a
// request passes the front end, the queue, the step sequencer, an input
// register and the reciprocal stages; the rest follow one per unstalled cycle.
// In steady state the step sequencer sets the rate for all but the smallest STEPS.
// A stall on the output freezes the whole back pipeline; the front end keeps
// taking requests until the queue is full.
// Reset (arst_n low) empties the queue and pipeline; nothing else is held.
module tone_sweep_period_generator #(
	parameter int STEPS = 50
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  tsp_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output tsp_pkg::out_item_t out_item
);
	import tsp_pkg::*;

	// Hold the step count within 1..STEPS_MAX
	localparam int STEP_N = (STEPS < 1) ? 1 : ((STEPS > STEPS_MAX) ? STEPS_MAX : STEPS);

	logic job_valid, q_full, q_nonempty, pop;
	job_t front_job, back_job;

	tsp_front #(.STEPS(STEP_N)) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.job_valid (job_valid),
		.job_ready (!q_full),
		.job       (front_job)
	);

	tsp_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (job_valid && !q_full),
		.push_job (front_job),
		.full     (q_full),
		.pop      (pop),
		.nonempty (q_nonempty),
		.pop_job  (back_job)
	);

	tsp_back #(.STEPS(STEP_N)) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (q_nonempty),
		.job_ready (pop),
		.job       (back_job),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// ===== sv/tsp_cdiv.sv =====
// Divider of a 16-bit value by a fixed divisor through reciprocal multiplication.
module tsp_cdiv #(
	parameter int DIVISOR = 50
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        load,
	input  logic        step,
	input  logic [15:0] dividend,
	output logic [15:0] quotient
);
	import tsp_pkg::*;

	localparam int PROD_W = 16 + RCP_W;
	// ceil(2^RCP_SH / DIVISOR): exact for every 16-bit dividend and divisor up to 64
	localparam longint unsigned RCP_WIDE =
		((64'd1 << RCP_SH) + 64'(DIVISOR) - 64'd1) / 64'(DIVISOR);
	localparam logic [RCP_W-1:0] RCP = RCP_W'(RCP_WIDE);

	logic [15:0]       dvd_q;
	logic [15:0]       quo_q;
	logic [PROD_W-1:0] prod;

	assign prod     = PROD_W'(dvd_q) * PROD_W'(RCP);
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (load) begin
			dvd_q <= dividend;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quo_q <= '0;
		end else if (step) begin
			quo_q <= prod[RCP_SH +: 16];
		end
	end

endmodule

// ===== sv/tsp_front.sv =====
// Front end: takes sweep requests and works out increment and step length.
module tsp_front #(
	parameter int STEPS = 50
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  tsp_pkg::in_item_t in_item,
	output logic              job_valid,
	input  logic              job_ready,
	output tsp_pkg::job_t     job
);
	import tsp_pkg::*;

	front_state_t       state_q, state_d;
	logic [14:0]        start_q;
	logic               neg_q;
	logic               load, step;
	logic signed [15:0] diff;
	logic [15:0]        mag;
	logic [15:0]        inc_q, ms_q;

	assign diff = $signed({1'b0, in_item.end_freq}) - $signed({1'b0, in_item.start_freq});
	assign mag  = diff[15] ? 16'(-diff) : diff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		job_valid = 1'b0;
		load      = 1'b0;
		step      = 1'b0;
		case (state_q)
			FR_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					load    = 1'b1;
					state_d = FR_DIV;
				end
			end
			FR_DIV: begin
				step    = 1'b1;
				state_d = FR_PUSH;
			end
			FR_PUSH: begin
				job_valid = 1'b1;
				if (job_ready) begin
					state_d = FR_IDLE;
				end
			end
			default: begin
				state_d = FR_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (load) begin
			start_q <= in_item.start_freq;
			neg_q   <= diff[15];
		end
	end

	tsp_cdiv #(.DIVISOR(STEPS)) u_inc_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.step     (step),
		.dividend (mag),
		.quotient (inc_q)
	);

	tsp_cdiv #(.DIVISOR(STEPS)) u_ms_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (load),
		.step     (step),
		.dividend (in_item.total_ms),
		.quotient (ms_q)
	);

	// Restore the sign of the increment, saturate the step length
	always_comb begin
		job.start_freq = start_q;
		job.inc        = neg_q ? $signed(16'(-inc_q)) : $signed(inc_q);
		job.step_ms    = (ms_q > 16'(MS_MAX)) ? MS_MAX : ms_q[10:0];
	end

endmodule

// ===== sv/tsp_queue.sv =====
// Two-entry job queue between front and back ends.
module tsp_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tsp_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          nonempty,
	output tsp_pkg::job_t pop_job
);
	import tsp_pkg::*;

	job_t       mem [QDEPTH];
	logic       wr_q, rd_q;
	logic [1:0] count_q;

	assign full     = count_q == 2'(QDEPTH);
	assign nonempty = count_q != '0;
	assign pop_job  = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full || pop) else $error("job pushed into full queue");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty) else $error("job popped from empty queue");

endmodule

// ===== sv/tsp_back.sv =====
// Back end: steps through a sweep and pipelines the tone period reciprocal.
module tsp_back #(
	parameter int STEPS = 50
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               job_valid,
	output logic               job_ready,
	input  tsp_pkg::job_t      job,
	output logic               out_valid,
	input  logic               out_ready,
	output tsp_pkg::out_item_t out_item
);
	import tsp_pkg::*;

	localparam logic [5:0] LAST_IDX = 6'(STEPS-1);

	logic                    active_q;
	logic [5:0]              idx_q;
	logic signed [ACC_W-1:0] f_q;
	logic signed [15:0]      inc_q;
	logic [10:0]             ms_q;
	logic                    adv, issue, gen_last, load;
	logic [FREQ_W-1:0]       f_clamp;

	logic              vld_s1;
	logic [FREQ_W-1:0] f_s1;
	side_t             side_s1;

	logic              dv_vld_s  [QBITS];
	logic [FREQ_W-1:0] dv_f_s    [QBITS];
	logic [REM_W-1:0]  dv_rem_s  [QBITS];
	logic [QBITS-1:0]  dv_q_s    [QBITS];
	side_t             dv_side_s [QBITS];

	logic [14:0] top_raw;

	assign adv       = !out_valid || out_ready;
	assign gen_last  = idx_q == LAST_IDX;
	assign issue     = active_q && adv;
	assign load      = job_valid && (!active_q || (issue && gen_last));
	assign job_ready = load;

	// Step sequencer: one step issued per advancing cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
		end else if (load) begin
			active_q <= 1'b1;
		end else if (issue && gen_last) begin
			active_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			idx_q <= '0;
			f_q   <= $signed(ACC_W'(job.start_freq));
			inc_q <= job.inc;
			ms_q  <= job.step_ms;
		end else if (issue) begin
			idx_q <= idx_q + 1'b1;
			f_q   <= f_q + ACC_W'(inc_q);
		end
	end

	always_comb begin
		if (f_q < $signed(ACC_W'(FREQ_MIN))) begin
			f_clamp = FREQ_MIN;
		end else if (f_q > $signed(ACC_W'(FREQ_MAX))) begin
			f_clamp = FREQ_MAX;
		end else begin
			f_clamp = f_q[FREQ_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			f_s1               <= f_clamp;
			side_s1.step_ms    <= ms_q;
			side_s1.step_index <= idx_q;
			side_s1.last_step  <= gen_last;
		end
	end

	// Restoring reciprocal, one quotient bit per stage, most significant first
	for (genvar j = 0; j < QBITS; j++) begin : g_div
		localparam int BIT = QBITS-1-j;

		logic              vld_in;
		logic [FREQ_W-1:0] f_in;
		logic [REM_W-1:0]  rem_in;
		logic [QBITS-1:0]  q_in, q_nx;
		side_t             side_in;
		logic [TRIAL_W-1:0] trial;
		logic               ge;

		if (j == 0) begin : g_first
			assign vld_in  = vld_s1;
			assign f_in    = f_s1;
			assign rem_in  = PERIOD_NUM;
			assign q_in    = '0;
			assign side_in = side_s1;
		end else begin : g_next
			assign vld_in  = dv_vld_s[j-1];
			assign f_in    = dv_f_s[j-1];
			assign rem_in  = dv_rem_s[j-1];
			assign q_in    = dv_q_s[j-1];
			assign side_in = dv_side_s[j-1];
		end

		assign trial = TRIAL_W'(f_in) << BIT;
		assign ge    = TRIAL_W'(rem_in) >= trial;

		always_comb begin
			q_nx      = q_in;
			q_nx[BIT] = ge;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				dv_vld_s[j] <= 1'b0;
			end else if (adv) begin
				dv_vld_s[j] <= vld_in;
			end
		end

		always_ff @(posedge clk) begin
			if (adv) begin
				dv_f_s[j]    <= f_in;
				dv_rem_s[j]  <= ge ? REM_W'(TRIAL_W'(rem_in) - trial) : rem_in;
				dv_q_s[j]    <= q_nx;
				dv_side_s[j] <= side_in;
			end
		end
	end

	assign out_valid = dv_vld_s[QBITS-1];
	assign top_raw   = {dv_q_s[QBITS-1], 3'b000};

	always_comb begin
		out_item.timer_top  = (top_raw < TOP_MIN) ? TOP_MIN : top_raw;
		out_item.step_ms    = dv_side_s[QBITS-1].step_ms;
		out_item.step_index = dv_side_s[QBITS-1].step_index;
		out_item.last_step  = dv_side_s[QBITS-1].last_step;
	end

	a_last_index: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.last_step |-> out_item.step_index == LAST_IDX)
		else $error("last step flagged at wrong index");
	a_sweep_runs: assert property (@(posedge clk) disable iff (!arst_n)
		issue && !gen_last |=> active_q)
		else $error("sweep stopped before its last step");
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !active_q || gen_last)
		else $error("job loaded over a running sweep");

endmodule
